FILE: design/rgb_neighbour_edge_map_core_defines.svh
// assertion macros for the rgb neighbour edge map core
// used by the top level only; expects clk and rst_n in scope
`ifndef RGB_NEIGHBOUR_EDGE_MAP_CORE_DEFINES_SVH
`define RGB_NEIGHBOUR_EDGE_MAP_CORE_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define RGBE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define RGBE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/rgbe_pkg.sv
// shared types, constants and the pixel compare function of the edge map core
// no dependencies
`default_nettype none

package rgbe_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  localparam int CH_W      = 8;
  localparam int PIX_W     = 3 * CH_W;
  localparam int THR_W     = 8;
  localparam int IW_W      = 11;
  localparam int IH_W      = 13;
  localparam int COL_W     = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W     = 12;
  localparam int OUT_COL_W = 10;
  localparam int OUT_ROW_W = 12;
  localparam int FLG_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int FLG_AW    = (FLG_DEPTH > 1) ? $clog2(FLG_DEPTH) : 1;
  localparam int CFG_AW    = 4;
  localparam int CFG_DW    = 32;
  localparam int RES_MAX   = 3;

  localparam logic [THR_W-1:0] THR_RESET    = THR_W'(100);
  localparam logic [IW_W-1:0]  WIDTH_RESET  = IW_W'(640);
  localparam logic [IH_W-1:0]  HEIGHT_RESET = IH_W'(480);

  // register index, taken from paddr[3:2]
  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_WIDTH     = 2'd1;
  localparam logic [1:0] REG_HEIGHT    = 2'd2;

  typedef logic [PIX_W-1:0]  pixel_t;
  typedef logic [COL_W-1:0]  col_t;
  typedef logic [COL_W:0]    wcnt_t;
  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [ROW_W:0]    hcnt_t;
  typedef logic [FLG_AW-1:0] fidx_t;

  typedef struct packed {
    logic                 done;
    logic                 last;
    logic                 edge_flag;
    logic [OUT_ROW_W-1:0] row;
    logic [OUT_COL_W-1:0] col;
  } res_t;

  typedef struct packed {
    res_t [RES_MAX-1:0] slots;
    logic [1:0]         cnt;
  } rb_load_t;

  typedef struct packed {
    logic re;
    col_t col;
  } ls_rd_t;

  typedef struct packed {
    logic   we;
    col_t   col;
    pixel_t pix;
    logic   flg_lo_we;
    logic   flg_lo;
    logic   flg_hi_we;
    logic   flg_hi;
  } ls_wr_t;

  // any channel apart by more than the threshold
  function automatic logic pixels_differ(pixel_t a, pixel_t b, logic [THR_W-1:0] thr);
    logic            d;
    logic [CH_W-1:0] x;
    logic [CH_W-1:0] y;
    logic [CH_W-1:0] m;
    d = 1'b0;
    for (int k = 0; k < 3; k++) begin
      x = a[k*CH_W +: CH_W];
      y = b[k*CH_W +: CH_W];
      m = (x > y) ? (x - y) : (y - x);
      if (m > thr) d = 1'b1;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

FILE: design/rgbe_ram.sv
// generic simple dual port ram, one write port, one registered read port
// no dependencies
`default_nettype none

module rgbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: design/rgbe_line_store.sv
// line buffers: upper row pixels and pending edge flags (even/odd flag banks)
// depends on rgbe_pkg and rgbe_ram
`default_nettype none

module rgbe_line_store (
  input  logic            clk,
  input  logic            rst_n,
  input  rgbe_pkg::ls_rd_t rd,
  input  rgbe_pkg::ls_wr_t wr,
  output rgbe_pkg::pixel_t upper_pix,
  output logic            pend_flag
);

  rgbe_pkg::col_t  lo_col;
  logic            lo_odd;
  rgbe_pkg::fidx_t rd_idx;
  rgbe_pkg::fidx_t lo_idx;
  rgbe_pkg::fidx_t hi_idx;
  logic            b0_we;
  logic            b1_we;
  rgbe_pkg::fidx_t b0_addr;
  rgbe_pkg::fidx_t b1_addr;
  logic            b0_d;
  logic            b1_d;
  logic            b0_q;
  logic            b1_q;
  logic            hit_lo;
  logic            hit_hi;
  logic            par_r;
  logic            fwd_hit_r;
  logic            fwd_val_r;

  assign lo_col = wr.col - rgbe_pkg::col_t'(1);
  assign lo_odd = lo_col[0];
  assign rd_idx = rgbe_pkg::fidx_t'(rd.col >> 1);
  assign lo_idx = rgbe_pkg::fidx_t'(lo_col >> 1);
  assign hi_idx = rgbe_pkg::fidx_t'(wr.col >> 1);

  // the two flag writes sit in neighbouring columns, so in different banks
  always_comb begin
    if (lo_odd) begin
      b0_we   = wr.flg_hi_we;
      b0_addr = hi_idx;
      b0_d    = wr.flg_hi;
      b1_we   = wr.flg_lo_we;
      b1_addr = lo_idx;
      b1_d    = wr.flg_lo;
    end else begin
      b0_we   = wr.flg_lo_we;
      b0_addr = lo_idx;
      b0_d    = wr.flg_lo;
      b1_we   = wr.flg_hi_we;
      b1_addr = hi_idx;
      b1_d    = wr.flg_hi;
    end
  end

  // a row wrap at width two reads the flag written in the same cycle
  assign hit_lo = wr.flg_lo_we && (rd.col == lo_col);
  assign hit_hi = wr.flg_hi_we && (rd.col == wr.col);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (rd.re) begin
      fwd_hit_r <= hit_lo || hit_hi;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.re) begin
      par_r     <= rd.col[0];
      fwd_val_r <= hit_hi ? wr.flg_hi : wr.flg_lo;
    end
  end

  rgbe_ram #(.WIDTH(rgbe_pkg::PIX_W), .DEPTH(rgbe_pkg::MAX_WIDTH)) u_pix_ram (
    .clk   (clk),
    .we    (wr.we),
    .waddr (wr.col),
    .wdata (wr.pix),
    .re    (rd.re),
    .raddr (rd.col),
    .rdata (upper_pix)
  );

  rgbe_ram #(.WIDTH(1), .DEPTH(rgbe_pkg::FLG_DEPTH)) u_flg_even (
    .clk   (clk),
    .we    (b0_we),
    .waddr (b0_addr),
    .wdata (b0_d),
    .re    (rd.re),
    .raddr (rd_idx),
    .rdata (b0_q)
  );

  rgbe_ram #(.WIDTH(1), .DEPTH(rgbe_pkg::FLG_DEPTH)) u_flg_odd (
    .clk   (clk),
    .we    (b1_we),
    .waddr (b1_addr),
    .wdata (b1_d),
    .re    (rd.re),
    .raddr (rd_idx),
    .rdata (b1_q)
  );

  assign pend_flag = fwd_hit_r ? fwd_val_r : (par_r ? b1_q : b0_q);

endmodule

`default_nettype wire

FILE: design/rgbe_result_buf.sv
// output register holding up to three results of one pixel, drained in order
// depends on rgbe_pkg
`default_nettype none

module rgbe_result_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load_en,
  input  rgbe_pkg::rb_load_t load,
  output logic               free,
  output logic               out_valid,
  input  logic               out_ready,
  output rgbe_pkg::res_t     out_res
);

  rgbe_pkg::res_t [rgbe_pkg::RES_MAX-1:0] slot_r;
  rgbe_pkg::res_t [rgbe_pkg::RES_MAX-1:0] slot_nxt;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic [1:0] idx_r;
  logic [1:0] idx_nxt;
  logic       last_one;
  logic       out_fire;

  assign out_valid = (cnt_r != 2'd0);
  assign out_fire  = out_valid && out_ready;
  assign last_one  = (idx_r == (cnt_r - 2'd1));
  assign free      = !out_valid || (out_ready && last_one);

  // flag the final result of the run
  always_comb begin
    slot_nxt = load.slots;
    for (int i = 0; i < rgbe_pkg::RES_MAX; i++) begin
      slot_nxt[i].last = (2'(i) == (load.cnt - 2'd1));
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    if (load_en) begin
      cnt_nxt = load.cnt;
      idx_nxt = 2'd0;
    end else if (out_fire) begin
      if (last_one) begin
        cnt_nxt = 2'd0;
        idx_nxt = 2'd0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      idx_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) slot_r <= slot_nxt;
  end

  always_comb begin
    unique case (idx_r)
      2'd0:    out_res = slot_r[0];
      2'd1:    out_res = slot_r[1];
      default: out_res = slot_r[2];
    endcase
  end

endmodule

`default_nettype wire

FILE: design/rgb_neighbour_edge_map_core.sv
// channel  | role            | payload
// cfg_     | apb slave       | threshold @0x0, width @0x4, height @0x8
// in_      | stream slave    | tdata: red[7:0] green[15:8] blue[23:16]
// out_     | stream master   | tdata: col[9:0] row[21:10] edge[22]; tlast: last of run;
//          |                 | tuser: frame done
// one pixel accepted per cycle while the result buffer is free; rows other than the last
// give at most one result per pixel, the last row up to three, drained one per cycle while
// out_tready is high, so such a pixel may hold the input; each pixel passes the input register and
// then the result buffer; ram reads issued at acceptance bring line buffer data with the pixel
// reset (synchronous) clears counters and neighbour state; line buffers are not cleared
// a stalled output holds the input register, which holds in_tready low
// top level of the edge map core; depends on rgbe_pkg, rgbe_line_store,
// rgbe_result_buf and the assertion macro header
`default_nettype none

`include "rgb_neighbour_edge_map_core_defines.svh"

module rgb_neighbour_edge_map_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [rgbe_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [rgbe_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [rgbe_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [23:0]                 in_tdata,   // red, green, blue
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [23:0]                 out_tdata,  // out_col, out_row, is_edge, zero pad
  output logic                        out_tlast,
  output logic [0:0]                  out_tuser   // frame_done
);

  logic [rgbe_pkg::THR_W-1:0] thr_r;
  logic [rgbe_pkg::IW_W-1:0]  width_r;
  logic [rgbe_pkg::IH_W-1:0]  height_r;
  logic                       cfg_wr;

  rgbe_pkg::col_t   col_cnt_r;
  rgbe_pkg::col_t   col_cnt_nxt;
  rgbe_pkg::row_t   row_cnt_r;
  rgbe_pkg::row_t   row_cnt_nxt;
  rgbe_pkg::wcnt_t  w_eff;
  rgbe_pkg::hcnt_t  h_eff;
  rgbe_pkg::col_t   acc_col;
  logic             acc_lcol;
  logic             acc_lrow;
  logic             in_fire;

  logic             s1_valid_r;
  logic             s1_valid_nxt;
  rgbe_pkg::pixel_t s1_pix_r;
  rgbe_pkg::col_t   s1_col_r;
  rgbe_pkg::row_t   s1_row_r;
  logic             s1_lcol_r;
  logic             s1_lrow_r;
  logic             s1_exec;

  rgbe_pkg::pixel_t left_pix_r;
  logic             lvf_r;

  rgbe_pkg::ls_rd_t   ls_rd;
  rgbe_pkg::ls_wr_t   ls_wr;
  rgbe_pkg::pixel_t   upper_pix;
  logic               pend_flag;
  logic               vdiff;
  logic               hdiff;
  logic               fl_left;
  logic               fl_self;
  rgbe_pkg::res_t [rgbe_pkg::RES_MAX-1:0] cand;
  logic [rgbe_pkg::RES_MAX-1:0]           cv;
  rgbe_pkg::rb_load_t rb_load;
  logic               rb_free;
  rgbe_pkg::res_t     out_res;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= rgbe_pkg::THR_RESET;
      width_r  <= rgbe_pkg::WIDTH_RESET;
      height_r <= rgbe_pkg::HEIGHT_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        rgbe_pkg::REG_THRESHOLD: thr_r    <= cfg_pwdata[rgbe_pkg::THR_W-1:0];
        rgbe_pkg::REG_WIDTH:     width_r  <= cfg_pwdata[rgbe_pkg::IW_W-1:0];
        rgbe_pkg::REG_HEIGHT:    height_r <= cfg_pwdata[rgbe_pkg::IH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      rgbe_pkg::REG_THRESHOLD: cfg_prdata = rgbe_pkg::CFG_DW'(thr_r);
      rgbe_pkg::REG_WIDTH:     cfg_prdata = rgbe_pkg::CFG_DW'(width_r);
      rgbe_pkg::REG_HEIGHT:    cfg_prdata = rgbe_pkg::CFG_DW'(height_r);
      default:                 cfg_prdata = '0;
    endcase
  end

  // effective frame size and position of the pixel being accepted
  always_comb begin
    if (int'(width_r) < 2) begin
      w_eff = rgbe_pkg::wcnt_t'(2);
    end else if (int'(width_r) > rgbe_pkg::MAX_WIDTH) begin
      w_eff = rgbe_pkg::wcnt_t'(rgbe_pkg::MAX_WIDTH);
    end else begin
      w_eff = rgbe_pkg::wcnt_t'(width_r);
    end
    if (int'(height_r) < 1) begin
      h_eff = rgbe_pkg::hcnt_t'(1);
    end else if (int'(height_r) > rgbe_pkg::MAX_HEIGHT) begin
      h_eff = rgbe_pkg::hcnt_t'(rgbe_pkg::MAX_HEIGHT);
    end else begin
      h_eff = rgbe_pkg::hcnt_t'(height_r);
    end
    if (int'(col_cnt_r) > rgbe_pkg::MAX_WIDTH - 1) begin
      acc_col = rgbe_pkg::col_t'(rgbe_pkg::MAX_WIDTH - 1);
    end else begin
      acc_col = col_cnt_r;
    end
  end

  assign acc_lcol = rgbe_pkg::wcnt_t'(acc_col) >= (w_eff - rgbe_pkg::wcnt_t'(1));
  assign acc_lrow = rgbe_pkg::hcnt_t'(row_cnt_r) >= (h_eff - rgbe_pkg::hcnt_t'(1));

  assign in_tready = !s1_valid_r || s1_exec;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    if (in_fire) begin
      if (acc_lcol) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = acc_lrow ? '0 : (row_cnt_r + rgbe_pkg::row_t'(1));
      end else begin
        col_cnt_nxt = acc_col + rgbe_pkg::col_t'(1);
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_exec) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r  <= '0;
      row_cnt_r  <= '0;
      s1_valid_r <= 1'b0;
      left_pix_r <= '0;
      lvf_r      <= 1'b0;
    end else begin
      col_cnt_r  <= col_cnt_nxt;
      row_cnt_r  <= row_cnt_nxt;
      s1_valid_r <= s1_valid_nxt;
      if (s1_exec) begin
        left_pix_r <= s1_pix_r;
        lvf_r      <= vdiff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pix_r  <= in_tdata;
      s1_col_r  <= acc_col;
      s1_row_r  <= row_cnt_r;
      s1_lcol_r <= acc_lcol;
      s1_lrow_r <= acc_lrow;
    end
  end

  // line buffers: read at acceptance, written when the pixel is evaluated
  assign ls_rd.re  = in_fire;
  assign ls_rd.col = acc_col;

  assign ls_wr.we        = s1_exec;
  assign ls_wr.col       = s1_col_r;
  assign ls_wr.pix       = s1_pix_r;
  assign ls_wr.flg_lo_we = s1_exec && (s1_col_r != '0);
  assign ls_wr.flg_lo    = fl_left;
  assign ls_wr.flg_hi_we = s1_exec && s1_lcol_r;
  assign ls_wr.flg_hi    = fl_self;

  rgbe_line_store u_line_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd        (ls_rd),
    .wr        (ls_wr),
    .upper_pix (upper_pix),
    .pend_flag (pend_flag)
  );

  // neighbour compares and the result list of this pixel
  assign vdiff   = (s1_row_r != '0) && rgbe_pkg::pixels_differ(s1_pix_r, upper_pix, thr_r);
  assign hdiff   = (s1_col_r != '0) && rgbe_pkg::pixels_differ(s1_pix_r, left_pix_r, thr_r);
  assign fl_left = lvf_r || hdiff;
  assign fl_self = vdiff || hdiff;

  always_comb begin
    cand[0].col       = rgbe_pkg::OUT_COL_W'(s1_col_r);
    cand[0].row       = rgbe_pkg::OUT_ROW_W'(s1_row_r - rgbe_pkg::row_t'(1));
    cand[0].edge_flag = pend_flag || vdiff;
    cand[0].last      = 1'b0;
    cand[0].done      = 1'b0;
    cand[1].col       = rgbe_pkg::OUT_COL_W'(s1_col_r - rgbe_pkg::col_t'(1));
    cand[1].row       = rgbe_pkg::OUT_ROW_W'(s1_row_r);
    cand[1].edge_flag = fl_left;
    cand[1].last      = 1'b0;
    cand[1].done      = 1'b0;
    cand[2].col       = rgbe_pkg::OUT_COL_W'(s1_col_r);
    cand[2].row       = rgbe_pkg::OUT_ROW_W'(s1_row_r);
    cand[2].edge_flag = fl_self;
    cand[2].last      = 1'b0;
    cand[2].done      = 1'b1;
    cv[0] = (s1_row_r != '0);
    cv[1] = (s1_col_r != '0) && s1_lrow_r;
    cv[2] = s1_lcol_r && s1_lrow_r;
    // pack present results to the front
    rb_load.slots[0] = cv[0] ? cand[0] : (cv[1] ? cand[1] : cand[2]);
    rb_load.slots[1] = (cv[0] && cv[1]) ? cand[1] : cand[2];
    rb_load.slots[2] = cand[2];
    rb_load.cnt      = 2'($countones(cv));
  end

  assign s1_exec = s1_valid_r && rb_free;

  rgbe_result_buf u_result_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_en   (s1_exec),
    .load      (rb_load),
    .free      (rb_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {1'b0, out_res.edge_flag, out_res.row, out_res.col};
  assign out_tlast = out_res.last;
  assign out_tuser = out_res.done;

  `RGBE_ASSERT_SAME(a_done_is_last, out_tvalid && out_tuser[0], out_tlast, "frame end not last of run")
  `RGBE_ASSERT_SAME(a_hold_blocks_in, s1_valid_r && !s1_exec, !in_tready, "input taken over held pixel")
  `RGBE_ASSERT_NEXT(a_lower_row_emits, s1_exec && (s1_row_r != '0), out_tvalid, "row result missing")

endmodule

`default_nettype wire
